// ===== src/srht_pkg.sv =====
// ----------------------------------------------------------------------------
// srht_pkg
// Shared types for the segment rectangle hit test unit.
// ----------------------------------------------------------------------------
package srht_pkg;

  // Advance enables for the pipeline stages inside each crossing unit.
  typedef struct packed {
    logic s2;
    logic s3;
  } srht_en_t;

endpackage

// ===== src/srht_seg_cross.sv =====
// ----------------------------------------------------------------------------
// srht_seg_cross
// Strict crossing test of segment a-b against segment c-d, two register
// stages: differences and bounding box check, then the cross product terms.
// The crossing flag is formed from the product registers.
// ----------------------------------------------------------------------------
module srht_seg_cross import srht_pkg::*; #(
  parameter int CW = 13
) (
  input  logic                 clk_i,
  input  srht_en_t             en_i,
  input  logic signed [CW-1:0] a_x_i,
  input  logic signed [CW-1:0] a_y_i,
  input  logic signed [CW-1:0] b_x_i,
  input  logic signed [CW-1:0] b_y_i,
  input  logic signed [CW-1:0] c_x_i,
  input  logic signed [CW-1:0] c_y_i,
  input  logic signed [CW-1:0] d_x_i,
  input  logic signed [CW-1:0] d_y_i,
  output logic                 cross_o
);

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int XW = PW + 1;

  logic signed [DW-1:0] ba_x_q, ba_y_q, ca_x_q, ca_y_q, da_x_q, da_y_q;
  logic signed [DW-1:0] ac_x_q, ac_y_q, dc_x_q, dc_y_q, bc_x_q, bc_y_q;
  logic                 rej2_q, rej3_q;
  logic signed [CW-1:0] ab_max_x, ab_min_x, ab_max_y, ab_min_y;
  logic signed [CW-1:0] cd_max_x, cd_min_x, cd_max_y, cd_min_y;
  logic                 rej_d;
  logic signed [PW-1:0] p_q [8];
  logic signed [XW-1:0] v0, v1, v2, v3;
  logic                 same_a, same_c;

  always_comb begin
    ab_max_x = (a_x_i > b_x_i) ? a_x_i : b_x_i;
    ab_min_x = (a_x_i < b_x_i) ? a_x_i : b_x_i;
    ab_max_y = (a_y_i > b_y_i) ? a_y_i : b_y_i;
    ab_min_y = (a_y_i < b_y_i) ? a_y_i : b_y_i;
    cd_max_x = (c_x_i > d_x_i) ? c_x_i : d_x_i;
    cd_min_x = (c_x_i < d_x_i) ? c_x_i : d_x_i;
    cd_max_y = (c_y_i > d_y_i) ? c_y_i : d_y_i;
    cd_min_y = (c_y_i < d_y_i) ? c_y_i : d_y_i;
    rej_d = (ab_max_x < cd_min_x) || (ab_max_y < cd_min_y) ||
            (cd_max_x < ab_min_x) || (cd_max_y < ab_min_y);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      rej2_q <= rej_d;
      ba_x_q <= DW'(b_x_i) - DW'(a_x_i);
      ba_y_q <= DW'(b_y_i) - DW'(a_y_i);
      ca_x_q <= DW'(c_x_i) - DW'(a_x_i);
      ca_y_q <= DW'(c_y_i) - DW'(a_y_i);
      da_x_q <= DW'(d_x_i) - DW'(a_x_i);
      da_y_q <= DW'(d_y_i) - DW'(a_y_i);
      ac_x_q <= DW'(a_x_i) - DW'(c_x_i);
      ac_y_q <= DW'(a_y_i) - DW'(c_y_i);
      dc_x_q <= DW'(d_x_i) - DW'(c_x_i);
      dc_y_q <= DW'(d_y_i) - DW'(c_y_i);
      bc_x_q <= DW'(b_x_i) - DW'(c_x_i);
      bc_y_q <= DW'(b_y_i) - DW'(c_y_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      rej3_q <= rej2_q;
      p_q[0] <= PW'(ca_x_q) * PW'(ba_y_q);
      p_q[1] <= PW'(ba_x_q) * PW'(ca_y_q);
      p_q[2] <= PW'(ba_x_q) * PW'(da_y_q);
      p_q[3] <= PW'(da_x_q) * PW'(ba_y_q);
      p_q[4] <= PW'(ac_x_q) * PW'(dc_y_q);
      p_q[5] <= PW'(dc_x_q) * PW'(ac_y_q);
      p_q[6] <= PW'(dc_x_q) * PW'(bc_y_q);
      p_q[7] <= PW'(bc_x_q) * PW'(dc_y_q);
    end
  end

  always_comb begin
    v0 = XW'(p_q[0]) - XW'(p_q[1]);
    v1 = XW'(p_q[2]) - XW'(p_q[3]);
    v2 = XW'(p_q[4]) - XW'(p_q[5]);
    v3 = XW'(p_q[6]) - XW'(p_q[7]);
    same_a = ((v0 > 0) && (v1 > 0)) || ((v0 < 0) && (v1 < 0));
    same_c = ((v2 > 0) && (v3 > 0)) || ((v2 < 0) && (v3 < 0));
    cross_o = !rej3_q && same_a && same_c;
  end

endmodule

// ===== src/segment_rectangle_hit_test_unit.sv =====
// ----------------------------------------------------------------------------
// segment_rectangle_hit_test_unit
// Reports whether a segment strictly crosses an edge or a diagonal of an
// axis-aligned rectangle.
// ----------------------------------------------------------------------------
// The unit accepts one request per cycle while the input is not stalled and
// returns one hit flag for each request, in order. The pipeline has four
// stages: input and corner registers, differences and bounding box checks,
// the cross product multipliers, and the output register holding the
// combined result. Stalls back up stage by stage, so empty stages still
// take new requests while a result waits.
// Touching and collinear contacts are not reported as hits.
module segment_rectangle_hit_test_unit import srht_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] seg_start_x_i,
  input  logic signed [COORD_BITS-1:0] seg_start_y_i,
  input  logic signed [COORD_BITS-1:0] seg_end_x_i,
  input  logic signed [COORD_BITS-1:0] seg_end_y_i,
  input  logic signed [COORD_BITS-1:0] box_left_i,
  input  logic signed [COORD_BITS-1:0] box_bottom_i,
  input  logic        [COORD_BITS-2:0] box_width_i,
  input  logic        [COORD_BITS-2:0] box_height_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         hit_o
);

  localparam int CW = COORD_BITS + 1;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  srht_en_t en;
  logic signed [CW-1:0] sx_q, sy_q, ex_q, ey_q, lx_q, rx_q, by_q, ty_q;
  logic [5:0] test_hit;
  logic hit_q;

  always_comb begin
    en4 = !v4_q || !out_stall_i;
    en3 = !v3_q || en4;
    en2 = !v2_q || en3;
    en1 = !v1_q || en2;
    en.s2 = en2;
    en.s3 = en3;
  end

  assign in_stall_o  = !en1;
  assign out_valid_o = v4_q;
  assign hit_o       = hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sx_q <= CW'(seg_start_x_i);
      sy_q <= CW'(seg_start_y_i);
      ex_q <= CW'(seg_end_x_i);
      ey_q <= CW'(seg_end_y_i);
      lx_q <= CW'(box_left_i);
      by_q <= CW'(box_bottom_i);
      rx_q <= CW'(box_left_i) + $signed({2'b00, box_width_i});
      ty_q <= CW'(box_bottom_i) + $signed({2'b00, box_height_i});
    end
  end

  // Left, right, top, bottom, rising diagonal, falling diagonal.
  srht_seg_cross #(.CW(CW)) u_left (
    .clk_i, .en_i(en), .a_x_i(sx_q), .a_y_i(sy_q), .b_x_i(ex_q), .b_y_i(ey_q),
    .c_x_i(lx_q), .c_y_i(by_q), .d_x_i(lx_q), .d_y_i(ty_q), .cross_o(test_hit[0]));
  srht_seg_cross #(.CW(CW)) u_right (
    .clk_i, .en_i(en), .a_x_i(sx_q), .a_y_i(sy_q), .b_x_i(ex_q), .b_y_i(ey_q),
    .c_x_i(rx_q), .c_y_i(by_q), .d_x_i(rx_q), .d_y_i(ty_q), .cross_o(test_hit[1]));
  srht_seg_cross #(.CW(CW)) u_top (
    .clk_i, .en_i(en), .a_x_i(sx_q), .a_y_i(sy_q), .b_x_i(ex_q), .b_y_i(ey_q),
    .c_x_i(lx_q), .c_y_i(ty_q), .d_x_i(rx_q), .d_y_i(ty_q), .cross_o(test_hit[2]));
  srht_seg_cross #(.CW(CW)) u_bottom (
    .clk_i, .en_i(en), .a_x_i(sx_q), .a_y_i(sy_q), .b_x_i(ex_q), .b_y_i(ey_q),
    .c_x_i(lx_q), .c_y_i(by_q), .d_x_i(rx_q), .d_y_i(by_q), .cross_o(test_hit[3]));
  srht_seg_cross #(.CW(CW)) u_rise (
    .clk_i, .en_i(en), .a_x_i(sx_q), .a_y_i(sy_q), .b_x_i(ex_q), .b_y_i(ey_q),
    .c_x_i(lx_q), .c_y_i(by_q), .d_x_i(rx_q), .d_y_i(ty_q), .cross_o(test_hit[4]));
  srht_seg_cross #(.CW(CW)) u_fall (
    .clk_i, .en_i(en), .a_x_i(sx_q), .a_y_i(sy_q), .b_x_i(ex_q), .b_y_i(ey_q),
    .c_x_i(lx_q), .c_y_i(ty_q), .d_x_i(rx_q), .d_y_i(by_q), .cross_o(test_hit[5]));

  always_ff @(posedge clk_i) begin
    if (en4) hit_q <= |test_hit;
  end

`ifndef SYNTH
  // A request is refused only when every stage holds a request and the
  // output is stalled.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && out_stall_i))
    else $error("input stalled while the pipeline has room");

  // A request in the product stage that may advance reaches the output.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en4) |=> out_valid_o)
    else $error("request lost between product stage and output");

  // A result held at the output keeps the request behind it in place.
  a_hold_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && out_stall_i && v3_q) |=> (v3_q && v4_q))
    else $error("product stage dropped a request behind a stalled result");
`endif

endmodule
